>>> design/vtp_pkg.sv
package vtp_pkg;

  localparam int NREG = 8;
  localparam int CFG_IW = 3;
  localparam int QDEPTH_DEF = 4;
  // One quotient bit per divider stage: 32 dividend bits plus 16 fraction bits.
  localparam int NSTEP = 48;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_DIR   = 1'b1;

  localparam logic [63:0] CFG_RESET [0:NREG-1] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               dvd;
    logic               ovf;
  } fe_item_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [47:0] dq;
    logic        neg;
    logic [31:0] res;
  } bk_lane_t;

  typedef struct packed {
    bk_lane_t [2:0] lane;
    logic [31:0]    d;
    logic           dvd;
    logic           ovf;
  } bk_stage_t;

  typedef struct packed {
    logic [31:0] v;
    logic        o;
  } sat_t;

  function automatic sat_t sat32(input logic signed [51:0] h);
    sat_t r;
    if (h[51:31] == {21{1'b0}} || h[51:31] == {21{1'b1}}) begin
      r.v = h[31:0];
      r.o = 1'b0;
    end else begin
      r.v = h[51] ? 32'h8000_0000 : 32'h7fff_ffff;
      r.o = 1'b1;
    end
    return r;
  endfunction

  // One restoring division step on magnitudes.
  function automatic bk_lane_t div_step(input bk_lane_t l, input logic [31:0] d);
    bk_lane_t r;
    logic [32:0] t;
    logic [32:0] diff;
    logic ge;
    r = l;
    t = {l.rem, l.dq[47]};
    diff = t - {1'b0, d};
    ge = (t >= {1'b0, d});
    r.rem = ge ? diff[31:0] : t[31:0];
    r.dq = {l.dq[46:0], ge};
    return r;
  endfunction

endpackage

>>> design/vertex_transform_persp_divide_unit.sv
// Q16.16 homogeneous vertex transform with perspective divide.
// Input channel: in_valid/in_stall with opcode and vec_x/vec_y/vec_z. A transaction
// completes on a clock edge with in_valid high and in_stall low. Opcode point applies the
// full 4x4 matrix and divides x, y and z by w when w is nonzero; opcode direction applies
// the upper 3x3 only. Output channel: out_valid/out_stall with res_x/res_y/res_z,
// divided and overflow, held steady while out_stall is high.
// The matrix is written through cfg_we/cfg_index/cfg_data, two entries per register;
// the user must write it only while no transaction is in flight, as the block does not enforce this.
// Throughput is one vertex per clock unless in_stall or out_stall holds the flow. A vertex
// passes the input, product and sum registers, the queue, the divider stages and the output
// register; the divider resolves one quotient bit per stage for all three coordinates.
// A queue between the transform front end and the divider lets the front keep accepting
// while the output is stalled; in_stall rises once the queue is full and s3 holds a vertex.
// Synchronous reset empties every pipeline and the queue and loads the matrix in CFG_RESET.
module vertex_transform_persp_divide_unit #(
  parameter int QDEPTH = vtp_pkg::QDEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [vtp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       opcode,
  input  logic signed [31:0]         vec_x,
  input  logic signed [31:0]         vec_y,
  input  logic signed [31:0]         vec_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         res_x,
  output logic signed [31:0]         res_y,
  output logic signed [31:0]         res_z,
  output logic                       divided,
  output logic                       overflow
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  vtp_pkg::fe_item_t push_item;
  vtp_pkg::fe_item_t pop_item;

  vtp_front u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .push(push), .push_item(push_item), .q_full(q_full)
  );

  vtp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_item(push_item), .full(q_full),
    .pop(pop), .pop_item(pop_item), .empty(q_empty)
  );

  vtp_back u_back (
    .clk(clk), .rst(rst),
    .pop_item(pop_item), .q_empty(q_empty), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_x(res_x), .res_y(res_y), .res_z(res_z),
    .divided(divided), .overflow(overflow)
  );

endmodule

>>> design/vtp_front.sv
module vtp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [vtp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [63:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic signed [31:0]          vec_x,
  input  logic signed [31:0]          vec_y,
  input  logic signed [31:0]          vec_z,
  output logic                        push,
  output vtp_pkg::fe_item_t           push_item,
  input  logic                        q_full
);

  logic [63:0]        cfg [0:vtp_pkg::NREG-1];
  logic signed [31:0] m [0:15];
  logic               en;

  logic               s1_v;
  logic               s1_dir;
  logic signed [31:0] s1_vec [0:2];

  logic               s2_v;
  logic               s2_dir;
  logic signed [63:0] prod [0:3][0:2];
  logic signed [31:0] trans [0:3];

  logic               s3_v;
  logic               s3_dir;
  logic signed [51:0] h [0:3];

  vtp_pkg::sat_t      sr [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vtp_pkg::NREG; i++) cfg[i] <= vtp_pkg::CFG_RESET[i];
    end else if (cfg_we) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < vtp_pkg::NREG; k++) begin
      m[2*k]   = cfg[k][31:0];
      m[2*k+1] = cfg[k][63:32];
    end
  end

  assign en       = !(s3_v && q_full);
  assign in_stall = s3_v && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dir    <= (opcode == vtp_pkg::OP_DIR);
      s1_vec[0] <= vec_x;
      s1_vec[1] <= vec_y;
      s1_vec[2] <= vec_z;

      s2_dir <= s1_dir;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) prod[r][c] <= m[4*r+c] * s1_vec[c];
        // Direction mode drops the translation column.
        trans[r] <= (s1_dir && r < 3) ? 32'sd0 : m[4*r+3];
      end

      // The exact sum floored to Q16.16 equals the per-term floor with carried remainders.
      s3_dir <= s2_dir;
      for (int r = 0; r < 4; r++) begin
        h[r] <= 52'($signed({{2{prod[r][0][63]}}, prod[r][0]}
                            + {{2{prod[r][1][63]}}, prod[r][1]}
                            + {{2{prod[r][2][63]}}, prod[r][2]}) >>> 16)
                + {{20{trans[r][31]}}, trans[r]};
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) sr[r] = vtp_pkg::sat32(h[r]);
    push           = s3_v && en;
    push_item.x    = sr[0].v;
    push_item.y    = sr[1].v;
    push_item.z    = sr[2].v;
    push_item.w    = sr[3].v;
    push_item.dvd  = !s3_dir && (sr[3].v != 32'd0);
    push_item.ovf  = sr[0].o || sr[1].o || sr[2].o || (!s3_dir && sr[3].o);
  end

endmodule

>>> design/vtp_queue.sv
module vtp_queue #(
  parameter int DEPTH = vtp_pkg::QDEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vtp_pkg::fe_item_t push_item,
  output logic              full,
  input  logic              pop,
  output vtp_pkg::fe_item_t pop_item,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vtp_pkg::fe_item_t mem [0:DEPTH-1];
  logic [AW-1:0]     wp;
  logic [AW-1:0]     rp;
  logic [CW-1:0]     cnt;

  assign full     = (cnt == CW'(DEPTH));
  assign empty    = (cnt == '0);
  assign pop_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_item;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("queue count lost a push");

endmodule

>>> design/vtp_back.sv
module vtp_back (
  input  logic               clk,
  input  logic               rst,
  input  vtp_pkg::fe_item_t  pop_item,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic signed [31:0] res_z,
  output logic               divided,
  output logic               overflow
);

  localparam int N = vtp_pkg::NSTEP;

  vtp_pkg::bk_stage_t s [0:N-1];
  logic               sv [0:N-1];
  vtp_pkg::bk_stage_t ld;
  logic               en;
  logic [31:0]        fin [0:2];
  logic               fin_ovf;

  function automatic vtp_pkg::bk_stage_t stage_step(input vtp_pkg::bk_stage_t a);
    vtp_pkg::bk_stage_t r;
    r = a;
    for (int j = 0; j < 3; j++) r.lane[j] = vtp_pkg::div_step(a.lane[j], a.d);
    return r;
  endfunction

  assign en  = !(out_valid && out_stall);
  assign pop = en && !q_empty;

  always_comb begin
    logic signed [31:0] c [0:2];
    c[0] = pop_item.x;
    c[1] = pop_item.y;
    c[2] = pop_item.z;
    ld.d   = pop_item.w[31] ? 32'(-pop_item.w) : pop_item.w;
    ld.dvd = pop_item.dvd;
    ld.ovf = pop_item.ovf;
    for (int j = 0; j < 3; j++) begin
      ld.lane[j].rem = '0;
      ld.lane[j].dq  = {(c[j][31] ? 32'(-c[j]) : c[j]), 16'h0000};
      ld.lane[j].neg = c[j][31] ^ pop_item.w[31];
      ld.lane[j].res = c[j];
    end
  end

  always_comb begin
    logic [47:0] q;
    fin_ovf = s[N-1].ovf;
    for (int j = 0; j < 3; j++) begin
      q = s[N-1].lane[j].dq;
      if (!s[N-1].dvd) begin
        fin[j] = s[N-1].lane[j].res;
      end else if (s[N-1].lane[j].neg) begin
        if (q > 48'h0000_8000_0000) begin
          fin[j]  = 32'h8000_0000;
          fin_ovf = 1'b1;
        end else begin
          fin[j] = 32'(-q[31:0]);
        end
      end else begin
        if (q > 48'h0000_7fff_ffff) begin
          fin[j]  = 32'h7fff_ffff;
          fin_ovf = 1'b1;
        end else begin
          fin[j] = q[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) sv[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sv[0] <= pop;
      for (int i = 1; i < N; i++) sv[i] <= sv[i-1];
      out_valid <= sv[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s[0] <= stage_step(ld);
      for (int i = 1; i < N; i++) s[i] <= stage_step(s[i-1]);
      res_x    <= fin[0];
      res_y    <= fin[1];
      res_z    <= fin[2];
      divided  <= s[N-1].dvd;
      overflow <= fin_ovf;
    end
  end

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (sv[N-1] && en) |=> out_valid)
    else $error("finished transaction did not reach the output register");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (sv[0] == $past(sv[0])))
    else $error("divider advanced while the output was stalled");
  a_pop_gate: assert property (@(posedge clk) disable iff (rst)
    pop |-> (en && !q_empty))
    else $error("queue popped without room in the divider");

endmodule

>>> bench/vertex_transform_persp_divide_unit_tb.sv
`timescale 1ns / 100ps

module vertex_transform_persp_divide_unit_tb;

  localparam int PIPE_LAT = 52;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_RANDOM = 1310;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        dv;
    logic        of;
  } vtx_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [vtp_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = vtp_pkg::OP_POINT;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic divided;
  logic overflow;

  logic signed [31:0] matrix [16];
  vtx_res_t pending_vertices [$];
  int err_cnt = 0;
  int cycle_cnt = 0;
  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  vertex_transform_persp_divide_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_x(res_x), .res_y(res_y), .res_z(res_z), .divided(divided), .overflow(overflow)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output stall: random idling, plus a long hold-off when a test requests one.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = 300;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= recv_idle_en && ($urandom_range(0, 99) < 10);
    end
  end

  function automatic longint row_dot(input int r, input bit trans,
                                     input logic signed [31:0] vx, input logic signed [31:0] vy,
                                     input logic signed [31:0] vz, inout bit ovf);
    logic signed [67:0] acc;
    logic signed [67:0] e0, e1, e2, c0, c1, c2;
    longint s;
    e0 = matrix[4*r];
    e1 = matrix[4*r+1];
    e2 = matrix[4*r+2];
    c0 = vx;
    c1 = vy;
    c2 = vz;
    acc = e0 * c0 + e1 * c1 + e2 * c2;
    acc = acc >>> 16;
    s = longint'(acc);
    if (trans) s = s + longint'(matrix[4*r+3]);
    if (s > 64'sd2147483647) begin
      ovf = 1'b1;
      s = 64'sd2147483647;
    end else if (s < -64'sd2147483648) begin
      ovf = 1'b1;
      s = -64'sd2147483648;
    end
    return s;
  endfunction

  function automatic vtx_res_t transform_vertex(input logic op, input logic signed [31:0] vx,
                                                input logic signed [31:0] vy,
                                                input logic signed [31:0] vz);
    vtx_res_t r;
    longint c [3];
    longint w;
    longint q;
    bit ovf;
    bit pt;
    ovf = 1'b0;
    pt = (op == vtp_pkg::OP_POINT);
    r.dv = 1'b0;
    for (int i = 0; i < 3; i++) c[i] = row_dot(i, pt, vx, vy, vz, ovf);
    if (pt) begin
      w = row_dot(3, 1'b1, vx, vy, vz, ovf);
      if (w != 0) begin
        r.dv = 1'b1;
        for (int i = 0; i < 3; i++) begin
          q = (c[i] * 65536) / w;
          if (q > 64'sd2147483647) begin
            ovf = 1'b1;
            q = 64'sd2147483647;
          end else if (q < -64'sd2147483648) begin
            ovf = 1'b1;
            q = -64'sd2147483648;
          end
          c[i] = q;
        end
      end
    end
    r.x = c[0][31:0];
    r.y = c[1][31:0];
    r.z = c[2][31:0];
    r.of = ovf;
    return r;
  endfunction

  task automatic write_matrix_reg(input int idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx[vtp_pkg::CFG_IW-1:0];
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    matrix[2*idx] = data[31:0];
    matrix[2*idx+1] = data[63:32];
  endtask

  task automatic load_matrix(input logic [63:0] r0, r1, r2, r3, r4, r5, r6, r7);
    write_matrix_reg(0, r0);
    write_matrix_reg(1, r1);
    write_matrix_reg(2, r2);
    write_matrix_reg(3, r3);
    write_matrix_reg(4, r4);
    write_matrix_reg(5, r5);
    write_matrix_reg(6, r6);
    write_matrix_reg(7, r7);
    @(posedge clk);
  endtask

  task automatic send_vertex(input logic op, input logic signed [31:0] vx,
                             input logic signed [31:0] vy, input logic signed [31:0] vz);
    bit stalled;
    if (send_idle_en && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    vec_x <= vx;
    vec_y <= vy;
    vec_z <= vz;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    pending_vertices.push_back(transform_vertex(op, vx, vy, vz));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  // Result checker: outputs are sampled mid-cycle and a transaction counts at the next edge.
  initial begin
    logic sv, ss;
    vtx_res_t got, want;
    forever begin
      @(negedge clk);
      sv = out_valid && !rst;
      ss = out_stall;
      got.x = res_x;
      got.y = res_y;
      got.z = res_z;
      got.dv = divided;
      got.of = overflow;
      @(posedge clk);
      if (sv && !ss) begin
        if (pending_vertices.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("Unexpected result x=%h y=%h z=%h", got.x, got.y, got.z);
        end else begin
          want = pending_vertices.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.dv !== want.dv || got.of !== want.of) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("Mismatch exp x=%h y=%h z=%h div=%b ovf=%b got x=%h y=%h z=%h div=%b ovf=%b",
                       want.x, want.y, want.z, want.dv, want.of,
                       got.x, got.y, got.z, got.dv, got.of);
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return $urandom;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [63:0] rand_reg();
    return {rand_entry(), rand_entry()};
  endfunction

  task automatic test_reset_identity();
    send_vertex(vtp_pkg::OP_POINT, 32'h0001_0000, 32'h0002_0000, -32'sh0003_0000);
    send_vertex(vtp_pkg::OP_DIR, 32'h0001_8000, -32'sh0000_4000, 32'h7fff_ffff);
    wait_drain();
  endtask

  task automatic test_directed();
    // Translation plus a projective row: w = z, so small z drives the quotient to saturation.
    load_matrix(64'h0000_0000_0001_0000, 64'h0003_0000_0000_0000,
                64'h0001_0000_0000_0000, 64'hfffe_0000_0000_0000,
                64'h0, 64'h0000_0000_0001_0000,
                64'h0, 64'h0000_0000_0001_0000);
    send_vertex(vtp_pkg::OP_POINT, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000);
    send_vertex(vtp_pkg::OP_POINT, 32'h0004_0000, 32'h0002_0000, -32'sh0002_0000);
    send_vertex(vtp_pkg::OP_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001);
    send_vertex(vtp_pkg::OP_POINT, 32'h8000_0000, 32'h8000_0000, -32'sh0000_0001);
    send_vertex(vtp_pkg::OP_POINT, 32'h1234_5678, 32'h0, 32'h0);
    send_vertex(vtp_pkg::OP_DIR, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    wait_drain();
    // Row 3 all zero gives w of zero, so nothing is divided.
    load_matrix(64'h7fff_ffff_7fff_ffff, 64'h7fff_ffff_7fff_ffff,
                64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                64'h0, 64'h0);
    send_vertex(vtp_pkg::OP_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(vtp_pkg::OP_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(vtp_pkg::OP_POINT, 32'h0, 32'h0, 32'h0);
    send_vertex(vtp_pkg::OP_POINT, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_vertex(vtp_pkg::OP_DIR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(vtp_pkg::OP_DIR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(vtp_pkg::OP_DIR, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001);
    wait_drain();
    // Extreme translation and w entries, with w saturating too.
    load_matrix(64'h0, 64'h7fff_ffff_0000_0000, 64'h0, 64'h8000_0000_0000_0000,
                64'h0, 64'hffff_ffff_0000_0000, 64'h7fff_ffff_7fff_ffff,
                64'h7fff_ffff_7fff_ffff);
    send_vertex(vtp_pkg::OP_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(vtp_pkg::OP_POINT, 32'h8000_0000, 32'h0, 32'h0);
    send_vertex(vtp_pkg::OP_POINT, 32'h0, 32'h0, 32'h0);
    send_vertex(vtp_pkg::OP_DIR, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    wait_drain();
  endtask

  task automatic test_random();
    int phase;
    int per_phase;
    per_phase = NUM_RANDOM / 5;
    for (phase = 0; phase < 5; phase++) begin
      load_matrix(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                  rand_reg(), rand_reg(), rand_reg(), rand_reg());
      send_idle_en = (phase != 2);
      recv_idle_en = (phase != 2);
      for (int n = 0; n < per_phase; n++)
        send_vertex($urandom_range(0, 3) == 0 ? vtp_pkg::OP_DIR : vtp_pkg::OP_POINT,
                    rand_coord(), rand_coord(), rand_coord());
      wait_drain();
    end
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    load_matrix(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                rand_reg(), rand_reg(), rand_reg(), 64'h0001_0000_0000_0000);
    hold_req = 1'b1;
    send_idle_en = 1'b0;
    for (int n = 0; n < 120; n++)
      send_vertex($urandom_range(0, 1) ? vtp_pkg::OP_DIR : vtp_pkg::OP_POINT,
                  rand_coord(), rand_coord(), rand_coord());
    send_idle_en = 1'b1;
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < vtp_pkg::NREG; i++) begin
      matrix[2*i] = vtp_pkg::CFG_RESET[i][31:0];
      matrix[2*i+1] = vtp_pkg::CFG_RESET[i][63:32];
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_identity();
    test_directed();
    test_random();
    test_backpressure();
    if (err_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
design/vtp_pkg.sv
design/vtp_front.sv
design/vtp_queue.sv
design/vtp_back.sv
design/vertex_transform_persp_divide_unit.sv
bench/vertex_transform_persp_divide_unit_tb.sv
